// File: rtl/core/pngu_pkg.sv
// Shared types, codes and sizes for the PNG scanline unfilter.
package pngu_pkg;

    localparam int DEF_MAX_ROW_BYTES       = 8192;
    localparam int DEF_MAX_BYTES_PER_PIXEL = 4;

    // Field widths of the internal work item, sized for the largest configuration, and the queue depth.
    localparam int IDX_W  = 16;
    localparam int SLOT_W = 3;
    localparam int Q_DEPTH = 2;

    localparam int ROW_BYTES_W = 14;
    localparam int BPP_W       = 3;

    // Configuration register indexes.
    localparam logic CFG_ROW_BYTES = 1'b0;
    localparam logic CFG_BPP       = 1'b1;

    // Filter type codes; FLT_BAD stands for any unknown type.
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_SUB   = 3'd1;
    localparam logic [2:0] FLT_UP    = 3'd2;
    localparam logic [2:0] FLT_AVG   = 3'd3;
    localparam logic [2:0] FLT_PAETH = 3'd4;
    localparam logic [2:0] FLT_BAD   = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       image_start;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_end;
        logic       bad_filter;
    } t_out;

    // One classified data byte handed from the front to the back.
    typedef struct packed {
        logic [7:0]        in_byte;
        logic [IDX_W-1:0]  idx;
        logic [SLOT_W-1:0] slot;
        logic              has_left;
        logic              first_row;
        logic [2:0]        filter;
        logic              last;
        logic              clr_hist;
    } t_item;

endpackage

// File: rtl/core/pngu_fifo.sv
// Small register queue with a fill count.
module pngu_fifo import pngu_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/core/pngu_front.sv
// Front end: row framing, filter byte capture and classification of data bytes.
module pngu_front import pngu_pkg::*; #(
    parameter int MAX_ROW_BYTES       = DEF_MAX_ROW_BYTES,
    parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BYTES_PER_PIXEL
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_in                    i_in,
    output logic                   o_full,
    input  logic [ROW_BYTES_W-1:0] i_row_bytes,
    input  logic [BPP_W-1:0]       i_bpp,
    output logic                   o_item_push,
    output t_item                  o_item,
    input  logic                   i_item_full
);
    localparam int IW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
    localparam int LW = 17;

    logic          r_in_row, r_first, r_clr_pend;
    logic [2:0]    r_filter;
    logic [IW-1:0] r_idx;
    logic [SW-1:0] r_cnt [0:MAX_BYTES_PER_PIXEL-1];

    logic          accept, is_data, last;
    logic [LW-1:0] len_c, idx_x;
    logic [3:0]    bpp_c;
    logic [SW-1:0] slot;

    assign o_full  = i_item_full;
    assign accept  = i_push && !i_item_full;
    assign is_data = r_in_row && !i_in.image_start;

    always_comb begin
        if (i_row_bytes == '0) begin
            len_c = LW'(1);
        end else if (LW'(i_row_bytes) > LW'(MAX_ROW_BYTES)) begin
            len_c = LW'(MAX_ROW_BYTES);
        end else begin
            len_c = LW'(i_row_bytes);
        end
        if (i_bpp == '0) begin
            bpp_c = 4'd1;
        end else if (4'(i_bpp) > 4'(MAX_BYTES_PER_PIXEL)) begin
            bpp_c = 4'(MAX_BYTES_PER_PIXEL);
        end else begin
            bpp_c = 4'(i_bpp);
        end
    end

    assign idx_x = LW'(r_idx);
    assign last  = (idx_x >= len_c - 1'b1);
    // one modulo counter per possible pixel size, so the slot follows idx % bpp
    assign slot  = r_cnt[SW'(bpp_c - 4'd1)];

    always_comb begin
        o_item.in_byte   = i_in.in_byte;
        o_item.idx       = IDX_W'(r_idx);
        o_item.slot      = SLOT_W'(slot);
        o_item.has_left  = (idx_x >= LW'(bpp_c));
        o_item.first_row = r_first;
        o_item.filter    = r_filter;
        o_item.last      = last;
        o_item.clr_hist  = r_clr_pend;
    end
    assign o_item_push = accept && is_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= 1'b0;
            r_first    <= 1'b1;
            r_clr_pend <= 1'b0;
            r_filter   <= FLT_NONE;
            r_idx      <= '0;
            for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (accept) begin
            if (!is_data) begin
                r_filter   <= (i_in.in_byte > 8'd4) ? FLT_BAD : i_in.in_byte[2:0];
                r_in_row   <= 1'b1;
                r_idx      <= '0;
                r_first    <= r_first | i_in.image_start;
                r_clr_pend <= r_clr_pend | i_in.image_start;
                for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
                    r_cnt[k] <= '0;
                end
            end else begin
                r_clr_pend <= 1'b0;
                if (last) begin
                    r_in_row <= 1'b0;
                    r_first  <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
                        r_cnt[k] <= (r_cnt[k] == SW'(k)) ? '0 : r_cnt[k] + 1'b1;
                    end
                end
            end
        end
    end

endmodule

// File: rtl/core/pngu_back.sv
// Back end: line store, neighbor history and byte reconstruction.
module pngu_back import pngu_pkg::*; #(
    parameter int MAX_ROW_BYTES       = DEF_MAX_ROW_BYTES,
    parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BYTES_PER_PIXEL
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    input  t_item i_item,
    output logic  o_item_pop,
    output logic  o_res_push,
    output t_out  o_res,
    input  logic  i_res_full
);
    localparam int IW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] da, db, dc;
        logic        [9:0]  pa, pb, pc;
        da = $signed({3'b0, b}) - $signed({3'b0, c});
        db = $signed({3'b0, a}) - $signed({3'b0, c});
        dc = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({2'b0, c, 1'b0});
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

    logic [7:0] r_line [0:MAX_ROW_BYTES-1];
    logic [7:0] r_left [0:MAX_BYTES_PER_PIXEL-1];
    logic [7:0] r_ul   [0:MAX_BYTES_PER_PIXEL-1];

    logic       r_s2_v;
    t_item      r_s2;
    logic [7:0] r_rdata, r_byp_data;
    logic       r_byp;

    logic          fire2, load2;
    logic [SW-1:0] slot;
    logic [7:0]    a, b, c, pred, res;
    logic [8:0]    sum_ab;

    assign fire2      = r_s2_v && !i_res_full;
    assign load2      = i_item_valid && (!r_s2_v || fire2);
    assign o_item_pop = load2;

    assign slot = r_s2.slot[SW-1:0];

    always_comb begin
        b = r_s2.first_row ? 8'd0 : (r_byp ? r_byp_data : r_rdata);
        a = (r_s2.has_left && !r_s2.clr_hist) ? r_left[slot] : 8'd0;
        c = (r_s2.has_left && !r_s2.clr_hist && !r_s2.first_row) ? r_ul[slot] : 8'd0;
        sum_ab = {1'b0, a} + {1'b0, b};
        case (r_s2.filter)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = sum_ab[8:1];
            FLT_PAETH: pred = paeth(a, b, c);
            default:   pred = 8'd0;
        endcase
        res = r_s2.in_byte + pred;
    end

    assign o_res_push       = fire2;
    assign o_res.out_byte   = res;
    assign o_res.row_end    = r_s2.last;
    assign o_res.bad_filter = (r_s2.filter == FLT_BAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
                r_left[k] <= '0;
                r_ul[k]   <= '0;
            end
        end else begin
            if (load2) begin
                r_s2_v <= 1'b1;
            end else if (fire2) begin
                r_s2_v <= 1'b0;
            end
            if (fire2) begin
                for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
                    if (SW'(k) == slot) begin
                        r_left[k] <= res;
                        r_ul[k]   <= b;
                    end else if (r_s2.clr_hist) begin
                        r_left[k] <= '0;
                        r_ul[k]   <= '0;
                    end
                end
            end
        end
    end

    // line store: read on load into the compute stage, write on the transfer out of it;
    // a write to the address being read is forwarded
    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_s2       <= i_item;
            r_rdata    <= r_line[i_item.idx[IW-1:0]];
            r_byp      <= fire2 && (r_s2.idx == i_item.idx);
            r_byp_data <= res;
        end
        if (fire2) begin
            r_line[r_s2.idx[IW-1:0]] <= res;
        end
    end

endmodule

// File: rtl/core/png_scanline_unfilter.sv
// PNG scanline unfilter (None/Sub/Up/Average/Paeth reconstruction), top level.
// Takes one byte of the decompressed stream per cycle while o_full is low and returns one
// reconstructed byte per data byte, also one per cycle while the output queue has room;
// filter bytes give no result. A result passes the item queue, then the compute stage register,
// loaded together with the line store read, then the output queue, with the left-neighbor loop
// closed in the compute stage. The previous row lives in a MAX_ROW_BYTES x 8 line store with one
// read and one write each cycle; it needs no clearing, as the first row of an image
// never reads it. Rows with an unknown filter type pass through with bad_filter set.
// Write row_bytes (index 0) and bytes_per_pixel (index 1) only while no byte is in flight.
module png_scanline_unfilter import pngu_pkg::*; #(
    parameter int MAX_ROW_BYTES       = DEF_MAX_ROW_BYTES,
    parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BYTES_PER_PIXEL
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_in                    i_in,
    output logic                   o_full,
    output logic                   o_empty,
    input  logic                   i_pop,
    output t_out                   o_out,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [ROW_BYTES_W-1:0] i_cfg_data
);
    localparam int ITEM_W = $bits(t_item);
    localparam int OUT_W  = $bits(t_out);

    logic [ROW_BYTES_W-1:0] r_row_bytes;
    logic [BPP_W-1:0]       r_bpp;

    logic  item_push, item_full, item_empty, item_pop;
    t_item item_in, item_out;
    logic  res_push, res_full;
    t_out  res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= ROW_BYTES_W'(1);
            r_bpp       <= BPP_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_BYTES: r_row_bytes <= i_cfg_data;
                CFG_BPP:       r_bpp       <= i_cfg_data[BPP_W-1:0];
                default:       r_bpp       <= r_bpp;
            endcase
        end
    end

    pngu_front #(
        .MAX_ROW_BYTES       (MAX_ROW_BYTES),
        .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .i_row_bytes (r_row_bytes),
        .i_bpp       (r_bpp),
        .o_item_push (item_push),
        .o_item      (item_in),
        .i_item_full (item_full)
    );

    pngu_fifo #(
        .W     (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_data  (item_in),
        .o_full  (item_full),
        .i_pop   (item_pop),
        .o_data  (item_out),
        .o_empty (item_empty)
    );

    pngu_back #(
        .MAX_ROW_BYTES       (MAX_ROW_BYTES),
        .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!item_empty),
        .i_item       (item_out),
        .o_item_pop   (item_pop),
        .o_res_push   (res_push),
        .o_res        (res),
        .i_res_full   (res_full)
    );

    pngu_fifo #(
        .W     (OUT_W),
        .DEPTH (Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_out),
        .o_empty (o_empty)
    );

endmodule

// File: verif/tb.sv
// Self-checking testbench for png_scanline_unfilter: directed table, then random image streams.
module tb;
    import pngu_pkg::*;

    localparam int ROWS_MAX     = DEF_MAX_ROW_BYTES;
    localparam int BPP_MAX      = DEF_MAX_BYTES_PER_PIXEL;
    localparam int IDLE_PCT     = 28;
    localparam int QUIET_FROM   = 1200;
    localparam int QUIET_TO     = 1800;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int SETTLE_CYC   = 10;
    localparam int STALL_LIMIT  = 5000;
    localparam int RAND_ITEMS   = 1600;
    localparam int BIG_PHASE    = 4;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out want;
    } t_byte_stim;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              cfg_index;
        logic [13:0]       cfg_data;
        t_byte_stim        stim;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_push;
    t_in                    i_in;
    logic                   o_full;
    logic                   o_empty;
    logic                   i_pop;
    t_out                   o_out;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_index;
    logic [ROW_BYTES_W-1:0] i_cfg_data;

    png_scanline_unfilter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]             line_store [ROWS_MAX];
    logic [7:0]             left_hist [BPP_MAX];
    logic [7:0]             upleft_hist [BPP_MAX];
    logic [2:0]             cur_filter = FLT_NONE;
    int                     col_pos = 0;
    logic                   in_first_row = 1'b1;
    logic [ROW_BYTES_W-1:0] cfg_row_bytes = ROW_BYTES_W'(1);
    logic [2:0]             cfg_bpp = 3'd1;

    t_out       pending_bytes [$];
    t_byte_stim cur_byte;
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    int         stall_cnt = 0;
    int         pop_count = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    function automatic int eff_row_len(logic [ROW_BYTES_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > ROWS_MAX) n = ROWS_MAX;
        return n;
    endfunction

    function automatic int idle_pct();
        return (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) ? 0 : IDLE_PCT;
    endfunction

    function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int pa, pb, pc, ab, cc;
        pa = (b > c) ? int'(b) - int'(c) : int'(c) - int'(b);
        pb = (a > c) ? int'(a) - int'(c) : int'(c) - int'(a);
        ab = int'(a) + int'(b);
        cc = 2 * int'(c);
        pc = (ab > cc) ? ab - cc : cc - ab;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    task automatic unfilter_byte(input t_in it, output bit has, output t_out res);
        int         len, bpp, idx, slot;
        logic [7:0] a, b, c, pred, r;
        len = eff_row_len(cfg_row_bytes);
        bpp = (cfg_bpp < 1) ? 1 : ((cfg_bpp > BPP_MAX) ? BPP_MAX : int'(cfg_bpp));
        has = 1'b0;
        res = '0;
        if (it.image_start) begin
            in_first_row = 1'b1;
            col_pos = 0;
            for (int k = 0; k < BPP_MAX; k++) begin
                left_hist[k] = '0;
                upleft_hist[k] = '0;
            end
        end
        if (col_pos == 0) begin
            cur_filter = (it.in_byte > 8'd4) ? FLT_BAD : it.in_byte[2:0];
            col_pos = 1;
        end else begin
            idx = col_pos - 1;
            if (idx >= ROWS_MAX) idx = ROWS_MAX - 1;
            slot = idx % bpp;
            a = (idx >= bpp) ? left_hist[slot] : 8'd0;
            b = in_first_row ? 8'd0 : line_store[idx];
            c = (idx >= bpp && !in_first_row) ? upleft_hist[slot] : 8'd0;
            case (cur_filter)
                FLT_SUB:   pred = a;
                FLT_UP:    pred = b;
                FLT_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
                FLT_PAETH: pred = paeth_pick(a, b, c);
                default:   pred = 8'd0;
            endcase
            r = it.in_byte + pred;
            left_hist[slot] = r;
            upleft_hist[slot] = b;
            line_store[idx] = r;
            res.out_byte = r;
            res.row_end = (idx >= len - 1);
            res.bad_filter = (cur_filter == FLT_BAD);
            if (res.row_end) begin
                col_pos = 0;
                in_first_row = 1'b0;
            end else begin
                col_pos = col_pos + 1;
            end
            has = 1'b1;
        end
    endtask

    task automatic report_error(string msg);
        if (err_cnt < 10) $display("tb: %s", msg);
        err_cnt++;
    endtask

    // monitor: sample transfers at the rising edge
    always @(posedge i_clk) begin : mon
        bit   has, moved;
        t_out res, want;
        if (i_rst_n) begin
            cycle_cnt++;
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                if (i_cfg_index == CFG_ROW_BYTES) cfg_row_bytes = i_cfg_data;
                else cfg_bpp = i_cfg_data[2:0];
            end
            if (i_pop && !o_empty) begin
                moved = 1'b1;
                pop_count++;
                if (pending_bytes.size() == 0) begin
                    report_error($sformatf("unexpected result byte=%h end=%b bad=%b",
                                 o_out.out_byte, o_out.row_end, o_out.bad_filter));
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_out.out_byte !== want.out_byte || o_out.row_end !== want.row_end ||
                        o_out.bad_filter !== want.bad_filter)
                        report_error($sformatf(
                            "mismatch exp byte=%h end=%b bad=%b got byte=%h end=%b bad=%b",
                            want.out_byte, want.row_end, want.bad_filter,
                            o_out.out_byte, o_out.row_end, o_out.bad_filter));
                end
            end
            if (i_push && !o_full) begin
                moved = 1'b1;
                unfilter_byte(cur_byte.item, has, res);
                if (has) pending_bytes.insert(pending_bytes.size(),
                                              cur_byte.typed ? cur_byte.want : res);
            end
            stall_cnt = moved ? 0 : stall_cnt + 1;
        end
    end

    // receiver: random idling, one long hold-off so the input side backs up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pop = 1'b0;
        end else if (hold_left > 0) begin
            i_pop = 1'b0;
            hold_left--;
        end else if (!hold_done && pop_count >= HOLD_AFTER && i_push) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_pop = 1'b0;
        end else begin
            i_pop = ($urandom_range(99) >= idle_pct());
        end
    end

    initial begin
        wait (stall_cnt >= STALL_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    function automatic t_dir_row data_row(logic [7:0] x, logic start);
        t_dir_row r;
        r = '0;
        r.kind = ROW_BYTE;
        r.stim.item.in_byte = x;
        r.stim.item.image_start = start;
        return r;
    endfunction

    function automatic t_dir_row checked_row(logic [7:0] x, logic [7:0] ob, logic re, logic bad);
        t_dir_row r;
        r = data_row(x, 1'b0);
        r.stim.typed = 1'b1;
        r.stim.want.out_byte = ob;
        r.stim.want.row_end = re;
        r.stim.want.bad_filter = bad;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic idx, logic [13:0] v);
        t_dir_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg_index = idx;
        r.cfg_data = v;
        return r;
    endfunction

    // all driver tasks enter and leave at a falling edge
    task automatic send_item(t_byte_stim s);
        while ($urandom_range(99) < idle_pct()) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        cur_byte = s;
        i_in = s.item;
        i_push = 1'b1;
        do @(posedge i_clk); while (o_full);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [13:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // filter bytes give no result, so allow the pipeline to drain after the last one
    task automatic settle_block();
        i_push = 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    initial begin
        t_dir_row   dir_q [$];
        t_byte_stim phase_q [$];
        t_byte_stim s;
        int         cur_len, new_len, phase, rand_items, n, nrows, nbytes;
        bit         force_start, big;
        logic [13:0] row_val;
        logic [10:0] hi;
        logic [2:0]  bpp3;

        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROW_BYTES;
        i_cfg_data = '0;
        cur_byte = '0;
        for (int k = 0; k < ROWS_MAX; k++) line_store[k] = '0;
        for (int k = 0; k < BPP_MAX; k++) begin
            left_hist[k] = '0;
            upleft_hist[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset state: one-byte rows, filter None
        dir_q.insert(dir_q.size(), data_row(8'(FLT_NONE), 1'b1));
        dir_q.insert(dir_q.size(), checked_row(8'hFF, 8'hFF, 1'b1, 1'b0));
        dir_q.insert(dir_q.size(), cfg_row(CFG_ROW_BYTES, 14'd3));
        dir_q.insert(dir_q.size(), cfg_row(CFG_BPP, 14'd2));
        dir_q.insert(dir_q.size(), data_row(8'(FLT_SUB), 1'b1));
        dir_q.insert(dir_q.size(), data_row(8'h80, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'hFF, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'h80, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'(FLT_UP), 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'h80, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'h01, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'h00, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'(FLT_AVG), 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'hFF, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'hFF, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'hFF, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'(FLT_PAETH), 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'h01, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'h7F, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'hFE, 1'b0));
        // lowest unknown filter type: bytes pass through flagged
        dir_q.insert(dir_q.size(), data_row(8'd5, 1'b0));
        dir_q.insert(dir_q.size(), checked_row(8'h12, 8'h12, 1'b0, 1'b1));
        dir_q.insert(dir_q.size(), checked_row(8'h34, 8'h34, 1'b0, 1'b1));
        dir_q.insert(dir_q.size(), checked_row(8'h56, 8'h56, 1'b1, 1'b1));
        // new image in the middle of a row
        dir_q.insert(dir_q.size(), data_row(8'(FLT_SUB), 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'h55, 1'b0));
        dir_q.insert(dir_q.size(), data_row(8'(FLT_UP), 1'b1));
        dir_q.insert(dir_q.size(), checked_row(8'h9A, 8'h9A, 1'b0, 1'b0));

        cur_len = 1;
        for (int k = 0; k < dir_q.size(); k++) begin
            if (dir_q[k].kind == ROW_CFG) begin
                if (k == 0 || dir_q[k-1].kind != ROW_CFG) settle_block();
                if (dir_q[k].cfg_index == CFG_ROW_BYTES) cur_len = eff_row_len(dir_q[k].cfg_data);
                cfg_write(dir_q[k].cfg_index, dir_q[k].cfg_data);
                if (k + 1 == dir_q.size() || dir_q[k+1].kind != ROW_CFG) i_cfg_valid = 1'b0;
            end else begin
                send_item(dir_q[k].stim);
            end
        end

        phase = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS || phase <= BIG_PHASE) begin
            big = (phase == BIG_PHASE);
            n = $urandom_range(99);
            if (big) row_val = 14'h3FFF;
            else if (n < 4) row_val = 14'd0;
            else if (n < 8) row_val = 14'd1;
            else if (n < 75) row_val = 14'($urandom_range(2, 12));
            else if (n < 95) row_val = 14'($urandom_range(13, 64));
            else row_val = 14'($urandom_range(65, 300));
            bpp3 = 3'($urandom_range(0, 7));
            hi = 11'($urandom);
            new_len = eff_row_len(row_val);
            // a longer row than before would read line store entries never written
            force_start = (new_len > cur_len);
            cur_len = new_len;

            settle_block();
            cfg_write(CFG_ROW_BYTES, row_val);
            cfg_write(CFG_BPP, {hi, bpp3});
            i_cfg_valid = 1'b0;

            phase_q.delete();
            if (!big && $urandom_range(99) < 15) begin
                n = $urandom_range(20, 80);
                for (int j = 0; j < n; j++) begin
                    s = '0;
                    s.item.in_byte = 8'($urandom);
                    s.item.image_start = (j == 0 && force_start) || ($urandom_range(15) == 0);
                    phase_q.insert(phase_q.size(), s);
                end
            end else begin
                nrows = big ? 2 : $urandom_range(1, 6);
                for (int rw = 0; rw < nrows; rw++) begin
                    s = '0;
                    s.item.image_start = (rw == 0 && (force_start || $urandom_range(1) == 1)) ||
                                         ($urandom_range(19) == 0);
                    s.item.in_byte = ($urandom_range(9) < 8) ? 8'($urandom_range(0, 4))
                                                             : 8'($urandom_range(5, 255));
                    phase_q.insert(phase_q.size(), s);
                    nbytes = new_len;
                    // at the largest length only the start of the row is sent
                    if (big) nbytes = 20;
                    else if (rw == nrows - 1 && $urandom_range(99) < 40)
                        nbytes = $urandom_range(0, new_len - 1);
                    for (int j = 0; j < nbytes; j++) begin
                        if ($urandom_range(99) < 2) begin
                            s = '0;
                            s.item.image_start = 1'b1;
                            s.item.in_byte = 8'($urandom);
                            phase_q.insert(phase_q.size(), s);
                        end
                        s = '0;
                        s.item.in_byte = 8'($urandom);
                        phase_q.insert(phase_q.size(), s);
                    end
                end
            end
            foreach (phase_q[j]) send_item(phase_q[j]);
            rand_items += phase_q.size();
            phase++;
        end

        settle_block();
        if (pending_bytes.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_bytes.size()));
        if (err_cnt == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/pngu_pkg.sv
rtl/core/pngu_fifo.sv
rtl/core/pngu_front.sv
rtl/core/pngu_back.sv
rtl/core/png_scanline_unfilter.sv
verif/tb.sv
